// File: src/glyph_cell_renderer_defines.svh
// Assertion macros shared by the glyph cell renderer RTL.
`ifndef GLYPH_CELL_RENDERER_DEFINES_SVH
`define GLYPH_CELL_RENDERER_DEFINES_SVH
`ifndef SYNTHESIS
`define GCR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
`define GCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define GCR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define GCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/gcr_pkg.sv
// Types, constants and state codes of the glyph cell renderer.
`default_nettype none
package gcr_pkg;
	localparam int WIN_SIDE_DEF   = 4096;
	localparam int TEXT_COLS_DEF  = 128;
	localparam int TEXT_ROWS_DEF  = 64;
	localparam int FONT_CHARS_DEF = 256;

	localparam int GLYPH_SIDE = 8;
	localparam int CFG_DW     = 13;
	localparam int CFG_IW     = 2;

	localparam logic [12:0] WIN_WIDTH_RST  = 13'd640;
	localparam logic [12:0] WIN_HEIGHT_RST = 13'd480;
	localparam logic [7:0]  TEXT_COLS_RST  = 8'd80;
	localparam logic [6:0]  TEXT_ROWS_RST  = 7'd30;

	localparam logic ACT_DRAW = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

	typedef enum logic [CFG_IW-1:0] {
		REG_WIN_WIDTH,
		REG_WIN_HEIGHT,
		REG_TEXT_COLS,
		REG_TEXT_ROWS
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CELL,
		ST_STORE,
		ST_BASE,
		ST_FETCH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic        action;
		logic [7:0]  cell_x;
		logic [7:0]  cell_y;
		logic [7:0]  char_code;
		logic [23:0] fg_color;
		logic [23:0] bg_color;
		logic [2:0]  font_row;
		logic [7:0]  font_bits;
	} in_item_t;

	typedef struct packed {
		logic [23:0] pixel_address;
		logic [23:0] pixel_color;
		logic        last;
	} out_item_t;
endpackage
`default_nettype wire

// File: src/glyph_cell_renderer.sv
// Text-mode character generator: 8x8 font store, cell stores and pixel expansion.
// A load item writes one glyph row into the font store in the cycle it is
// accepted and the block is ready again at once. A draw item of a cell inside
// the grid goes from its accept cycle through the setup states (grid check
// with the cell index product, cell store write with the row base product,
// base address add), then for each visible glyph row one font read followed
// by one pixel per visible column. A cell whose pixels are all clipped ends
// after the cell store write, a cell outside the grid after the grid check.
// An output pixel not taken stalls the emission. One multiplier serves both
// products, one 24-bit adder the base add and the address steps; the cell
// index sum has its own adder. The single-port font read once per row and
// the output register, one pixel per cycle when not stalled, set the pace.
// The output register lets the next item be accepted while the final pixel waits.
`default_nettype none
`include "glyph_cell_renderer_defines.svh"
module glyph_cell_renderer #(
	parameter int MAX_WIN_SIDE  = gcr_pkg::WIN_SIDE_DEF,
	parameter int MAX_TEXT_COLS = gcr_pkg::TEXT_COLS_DEF,
	parameter int MAX_TEXT_ROWS = gcr_pkg::TEXT_ROWS_DEF,
	parameter int FONT_CHARS    = gcr_pkg::FONT_CHARS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [gcr_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [gcr_pkg::CFG_DW-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire gcr_pkg::in_item_t           in_item,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output gcr_pkg::out_item_t               out_item
);
	localparam int CELL_DEPTH = MAX_TEXT_COLS * MAX_TEXT_ROWS;
	localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
	localparam int FONT_DEPTH = FONT_CHARS * gcr_pkg::GLYPH_SIDE;
	localparam int FONT_AW    = $clog2(FONT_DEPTH);

	// configuration
	logic [12:0] win_width_q, win_height_q;
	logic [7:0]  text_cols_q;
	logic [6:0]  text_rows_q;

	// control
	gcr_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	// item and datapath registers
	logic [7:0]  cx_q, cy_q, code_q;
	logic [23:0] fg_q, bg_q;
	logic        code_ok_q;
	logic [23:0] prod_q, row_base_q, pix_addr_q;
	logic [2:0]  col_q, row_q, last_col_q, last_row_q;
	logic [7:0]  font_rd_q;
	gcr_pkg::out_item_t out_q;

	// memories
	logic [7:0]  font_mem [FONT_DEPTH];
	logic [7:0]  code_mem [CELL_DEPTH];
	logic [23:0] fg_mem   [CELL_DEPTH];
	logic [23:0] bg_mem   [CELL_DEPTH];

	// combinational
	logic [12:0] ww, wh;
	logic [8:0]  cols, rows;
	logic [10:0] px0, py0;
	logic        in_grid;
	logic        col_ok, row_ok, span_empty;
	logic [12:0] col_diff, row_diff;
	logic [2:0]  last_col_d, last_row_d;
	logic        mul_sel;
	logic [10:0] mul_a;
	logic [12:0] mul_b;
	logic [23:0] prod;
	logic [23:0] add_a, add_b, add_sum;
	logic        col_last, row_last;
	logic        emit_go, fetch_en, load_go, draw_go;
	logic [16:0] cell_sum;
	logic [CELL_AW-1:0] cell_idx;
	logic [10:0] font_wr_full, font_rd_full;
	logic [7:0]  glyph_bits;
	logic [23:0] pix_color;

	assign ww = (win_width_q > 13'(MAX_WIN_SIDE)) ? 13'(MAX_WIN_SIDE) : win_width_q;
	assign wh = (win_height_q > 13'(MAX_WIN_SIDE)) ? 13'(MAX_WIN_SIDE) : win_height_q;
	assign cols = ({1'b0, text_cols_q} > 9'(MAX_TEXT_COLS)) ? 9'(MAX_TEXT_COLS)
		: {1'b0, text_cols_q};
	assign rows = ({2'b0, text_rows_q} > 9'(MAX_TEXT_ROWS)) ? 9'(MAX_TEXT_ROWS)
		: {2'b0, text_rows_q};

	assign px0 = {cx_q, 3'b000};
	assign py0 = {cy_q, 3'b000};
	assign in_grid = ({1'b0, cx_q} < cols) && ({1'b0, cy_q} < rows);

	// visible columns and rows form a prefix of the glyph
	assign col_ok   = ww > {2'b0, px0};
	assign row_ok   = wh > {2'b0, py0};
	assign col_diff = ww - {2'b0, px0};
	assign row_diff = wh - {2'b0, py0};
	assign last_col_d = (col_diff >= 13'(gcr_pkg::GLYPH_SIDE)) ? 3'd7 : col_diff[2:0] - 3'd1;
	assign last_row_d = (row_diff >= 13'(gcr_pkg::GLYPH_SIDE)) ? 3'd7 : row_diff[2:0] - 3'd1;
	assign span_empty = !col_ok || !row_ok;

	// shared multiplier: cell index product, then row base product
	assign mul_a = mul_sel ? py0 : {3'b000, cy_q};
	assign mul_b = mul_sel ? ww : {4'b0000, cols};
	assign prod  = 24'(mul_a * mul_b);

	assign col_last = (col_q == last_col_q);
	assign row_last = (row_q == last_row_q);

	assign add_sum = add_a + add_b;

	assign cell_sum = {9'b0, cx_q} + {1'b0, prod_q[15:0]};
	assign cell_idx = cell_sum[CELL_AW-1:0];

	assign font_wr_full = {in_item.char_code, in_item.font_row};
	assign font_rd_full = {code_q, row_q};

	assign glyph_bits = code_ok_q ? font_rd_q : 8'h00;
	// bit 7 is the leftmost column, so the bit index is the inverted column
	assign pix_color = glyph_bits[~col_q] ? fg_q : bg_q;

	assign load_go = in_valid && in_ready && (in_item.action == gcr_pkg::ACT_LOAD);
	assign draw_go = in_valid && in_ready && (in_item.action == gcr_pkg::ACT_DRAW);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gcr_pkg::ST_IDLE: begin
				if (draw_go) state_d = gcr_pkg::ST_CELL;
			end
			gcr_pkg::ST_CELL: begin
				state_d = in_grid ? gcr_pkg::ST_STORE : gcr_pkg::ST_IDLE;
			end
			gcr_pkg::ST_STORE: begin
				state_d = span_empty ? gcr_pkg::ST_IDLE : gcr_pkg::ST_BASE;
			end
			gcr_pkg::ST_BASE: begin
				state_d = gcr_pkg::ST_FETCH;
			end
			gcr_pkg::ST_FETCH: begin
				state_d = gcr_pkg::ST_EMIT;
			end
			gcr_pkg::ST_EMIT: begin
				if (emit_go && col_last)
					state_d = row_last ? gcr_pkg::ST_IDLE : gcr_pkg::ST_FETCH;
			end
			default: begin
				state_d = gcr_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		mul_sel  = 1'b0;
		fetch_en = 1'b0;
		emit_go  = 1'b0;
		add_a    = pix_addr_q;
		add_b    = 24'd1;
		case (state_q)
			gcr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			gcr_pkg::ST_CELL: begin
				mul_sel = 1'b0;
			end
			gcr_pkg::ST_STORE: begin
				mul_sel = 1'b1;
			end
			gcr_pkg::ST_BASE: begin
				add_a = prod_q;
				add_b = {13'b0, px0};
			end
			gcr_pkg::ST_FETCH: begin
				fetch_en = 1'b1;
			end
			gcr_pkg::ST_EMIT: begin
				emit_go = !out_valid_q || out_ready;
				if (col_last) begin
					add_a = row_base_q;
					add_b = {11'b0, ww};
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= gcr_pkg::ST_IDLE;
			out_valid_q  <= 1'b0;
			win_width_q  <= gcr_pkg::WIN_WIDTH_RST;
			win_height_q <= gcr_pkg::WIN_HEIGHT_RST;
			text_cols_q  <= gcr_pkg::TEXT_COLS_RST;
			text_rows_q  <= gcr_pkg::TEXT_ROWS_RST;
		end else begin
			state_q <= state_d;
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (gcr_pkg::cfg_reg_t'(cfg_index))
					gcr_pkg::REG_WIN_WIDTH:  win_width_q  <= cfg_data;
					gcr_pkg::REG_WIN_HEIGHT: win_height_q <= cfg_data;
					gcr_pkg::REG_TEXT_COLS:  text_cols_q  <= cfg_data[7:0];
					gcr_pkg::REG_TEXT_ROWS:  text_rows_q  <= cfg_data[6:0];
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (draw_go) begin
			cx_q      <= in_item.cell_x;
			cy_q      <= in_item.cell_y;
			code_q    <= in_item.char_code;
			fg_q      <= in_item.fg_color;
			bg_q      <= in_item.bg_color;
			code_ok_q <= {1'b0, in_item.char_code} < 9'(FONT_CHARS);
		end
		if (state_q == gcr_pkg::ST_CELL || state_q == gcr_pkg::ST_STORE)
			prod_q <= prod;
		if (state_q == gcr_pkg::ST_STORE) begin
			last_col_q <= last_col_d;
			last_row_q <= last_row_d;
			row_q      <= 3'd0;
		end
		if (state_q == gcr_pkg::ST_BASE)
			row_base_q <= add_sum;
		if (fetch_en) begin
			pix_addr_q <= row_base_q;
			col_q      <= 3'd0;
		end
		if (emit_go) begin
			out_q.pixel_address <= pix_addr_q;
			out_q.pixel_color   <= pix_color;
			out_q.last          <= col_last && row_last;
			if (col_last) begin
				row_base_q <= add_sum;
				row_q      <= row_q + 3'd1;
			end else begin
				pix_addr_q <= add_sum;
				col_q      <= col_q + 3'd1;
			end
		end
	end

	// font store
	always_ff @(posedge clk) begin
		if (load_go && ({1'b0, in_item.char_code} < 9'(FONT_CHARS)))
			font_mem[font_wr_full[FONT_AW-1:0]] <= in_item.font_bits;
		if (fetch_en)
			font_rd_q <= font_mem[font_rd_full[FONT_AW-1:0]];
	end

	// cell stores
	always_ff @(posedge clk) begin
		if (state_q == gcr_pkg::ST_STORE) begin
			code_mem[cell_idx] <= code_q;
			fg_mem[cell_idx]   <= fg_q;
			bg_mem[cell_idx]   <= bg_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`GCR_ASSERT_NOW(a_counters_in_span, clk, arst_n, state_q == gcr_pkg::ST_EMIT,
		(col_q <= last_col_q) && (row_q <= last_row_q), "pixel counter beyond visible span")
	`GCR_ASSERT_NEXT(a_done_marks_last, clk, arst_n,
		(state_q == gcr_pkg::ST_EMIT) && (state_d == gcr_pkg::ST_IDLE),
		out_valid_q && out_q.last, "final pixel of a draw item not marked last")
	`GCR_ASSERT_NEXT(a_draw_starts, clk, arst_n, draw_go,
		state_q == gcr_pkg::ST_CELL, "accepted draw item did not start the sequence")
	`GCR_ASSERT_NOW(a_store_in_grid, clk, arst_n, state_q == gcr_pkg::ST_STORE,
		in_grid, "cell store written for a cell outside the grid")
endmodule
`default_nettype wire
